[rtl/kpra_pkg.sv]
// Package: shared constants and types for the reservation arbiter
`default_nettype none
package kpra_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int OWNER_BITS    = 8;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_UNREG    = 3'd1;
    localparam logic [2:0] CMD_SET      = 3'd2;
    localparam logic [2:0] CMD_CLEAR    = 3'd3;
    localparam logic [2:0] CMD_QUERY    = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // Entry record carried around the ring
    typedef struct packed {
        logic                  valid;
        logic [OWNER_BITS-1:0] owner;
        logic                  device;
        logic [31:0]           key;
        logic signed [31:0]    prio;
        logic [31:0]           flags;
        logic [63:0]           order;
    } entry_t;

    // Per-pass control broadcast to every cell
    typedef struct packed {
        logic                  rotate;
        logic                  upd_en;
        logic                  ins_en;
        logic                  del_en;
        logic [OWNER_BITS-1:0] owner;
        logic                  device;
        logic [31:0]           key;
        logic signed [31:0]    prio;
        logic [31:0]           flags;
        logic [63:0]           order;
    } ctrl_t;
endpackage
`default_nettype wire

[rtl/kpra_cell.sv]
// One storage cell of the rotating reservation ring
`default_nettype none
module kpra_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire kpra_pkg::ctrl_t ctrl,
    input  wire logic            head,
    input  wire kpra_pkg::entry_t prev,
    output kpra_pkg::entry_t     cur
);
    import kpra_pkg::*;

    entry_t data_reg;
    entry_t data_next;
    logic   valid_reg;

    assign cur = '{valid: valid_reg, owner: data_reg.owner, device: data_reg.device,
                   key: data_reg.key, prio: data_reg.prio,
                   flags: data_reg.flags, order: data_reg.order};

    // Only the head cell applies updates to the entry flowing in
    always_comb
    begin
        data_next = prev;
        if (head)
        begin
            if (ctrl.del_en && prev.valid && prev.owner == ctrl.owner)
                data_next.valid = 1'b0;
            if (ctrl.upd_en)
            begin
                data_next.prio  = ctrl.prio;
                data_next.flags = ctrl.flags;
            end
            if (ctrl.ins_en)
            begin
                data_next.valid  = 1'b1;
                data_next.owner  = ctrl.owner;
                data_next.device = ctrl.device;
                data_next.key    = ctrl.key;
                data_next.prio   = ctrl.prio;
                data_next.flags  = ctrl.flags;
                data_next.order  = ctrl.order;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.rotate)
            valid_reg <= data_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rotate)
            data_reg <= data_next;
    end
endmodule
`default_nettype wire

[rtl/kpra_ring.sv]
// Ring of cells; cell 0 is the head that sees every entry once per pass
`default_nettype none
module kpra_ring (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kpra_pkg::ctrl_t  ctrl,
    output kpra_pkg::entry_t      head_entry
);
    import kpra_pkg::*;

    entry_t cells [TABLE_ENTRIES];

    // Head cell takes from the last cell, others take from the one before
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        kpra_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .ctrl (ctrl),
            .head (g == 0),
            .prev (cells[(g + TABLE_ENTRIES - 1) % TABLE_ENTRIES]),
            .cur  (cells[g])
        );
    end

    assign head_entry = cells[TABLE_ENTRIES-1];
endmodule
`default_nettype wire

[rtl/keyed_priority_reservation_arbiter_unit.sv]
// Top level: command sequencer around the reservation ring
// Sequence: pass 1 finds hit and free slot, pass 2 applies the change and finds the winner,
// then the DONE state and the done strobe.
// One command at a time: start is taken only in idle; busy drops during the strobe cycle.
// Reset clears all entry valid bits, the order counter and active owner; enable resets to 1.
`default_nettype none
module keyed_priority_reservation_arbiter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [7:0]  owner_id,
    input  wire logic        device_kind,
    input  wire logic [31:0] key_code,
    input  wire logic signed [31:0] claim_priority,
    input  wire logic [31:0] claim_flags,
    output logic             done,
    output logic [1:0]       status,
    output logic             allowed,
    output logic             blocked_by_active,
    output logic [7:0]       active_owner_now,
    output logic [7:0]       winner_owner,
    output logic signed [31:0] winner_priority
);
    import kpra_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  enable_reg;
    logic [OWNER_BITS-1:0] active_reg;
    logic [63:0]           order_reg;
    logic [2:0]            cmd_reg;
    logic [OWNER_BITS-1:0] owner_reg;
    logic                  dev_reg;
    logic [31:0]           key_reg;
    logic signed [31:0]    prio_reg;
    logic [31:0]           flags_reg;
    logic                  hit_reg, free_reg;
    logic [IDX_BITS-1:0]   hit_idx_reg, free_idx_reg;
    logic                  w_found_reg;
    logic [OWNER_BITS-1:0] w_owner_reg;
    logic signed [31:0]    w_prio_reg;
    logic [63:0]           w_order_reg;
    logic [1:0]            status_reg;
    logic                  allowed_reg;
    logic                  do_upd, do_ins, do_del;
    logic                  done_reg;

    ctrl_t  ctrl;
    entry_t head_entry;
    entry_t after;
    logic   key_match;
    logic   reg_ok;

    kpra_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .head_entry(head_entry)
    );

    assign reg_ok = owner_reg != '0 && key_reg != '0;
    assign do_upd = cmd_reg == CMD_REGISTER && reg_ok && hit_reg;
    assign do_ins = cmd_reg == CMD_REGISTER && reg_ok && !hit_reg && free_reg;
    assign do_del = cmd_reg == CMD_UNREG && owner_reg != '0;

    // Head-cell update only in the apply pass: update and insert at the selected slot, delete at every slot
    always_comb
    begin
        ctrl          = '0;
        ctrl.rotate   = state_reg == S_SCAN || state_reg == S_APPLY;
        ctrl.upd_en   = state_reg == S_APPLY && do_upd
                        && cnt_reg[IDX_BITS-1:0] == hit_idx_reg;
        ctrl.ins_en   = state_reg == S_APPLY && do_ins
                        && cnt_reg[IDX_BITS-1:0] == free_idx_reg;
        ctrl.del_en   = state_reg == S_APPLY && do_del;
        ctrl.owner    = owner_reg;
        ctrl.device   = dev_reg;
        ctrl.key      = key_reg;
        ctrl.prio     = prio_reg;
        ctrl.flags    = flags_reg;
        ctrl.order    = order_reg + 64'd1;
    end

    // Entry as it will look after the head cell, for winner search
    always_comb
    begin
        after = head_entry;
        if (ctrl.del_en && head_entry.valid && head_entry.owner == owner_reg)
            after.valid = 1'b0;
        if (ctrl.upd_en)
        begin
            after.prio = prio_reg;
        end
        if (ctrl.ins_en)
        begin
            after.valid  = 1'b1;
            after.owner  = owner_reg;
            after.device = dev_reg;
            after.key    = key_reg;
            after.prio   = prio_reg;
            after.order  = ctrl.order;
        end
    end

    assign key_match = after.valid && after.device == dev_reg && after.key == key_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_SCAN;
            S_SCAN:  if (cnt_reg == CNT_BITS'(TABLE_ENTRIES - 1)) state_next = S_APPLY;
            S_APPLY: if (cnt_reg == CNT_BITS'(TABLE_ENTRIES - 1)) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = state_reg != S_IDLE;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            enable_reg <= 1'b1;
            active_reg <= '0;
            order_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == S_DONE;
            if (state_reg != state_next)
                cnt_reg <= '0;
            else if (ctrl.rotate)
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
                if (!cfg_wdata)
                    active_reg <= '0;
            end
            if (ctrl.ins_en)
                order_reg <= ctrl.order;
            if (state_reg == S_DONE)
            begin
                priority case (cmd_reg)
                    CMD_UNREG:
                        if (owner_reg != '0 && active_reg == owner_reg)
                            active_reg <= '0;
                    CMD_SET:
                        if (owner_reg != '0 && enable_reg)
                            active_reg <= owner_reg;
                    CMD_CLEAR:
                        if (owner_reg != '0 && active_reg == owner_reg)
                            active_reg <= '0;
                    default: ;
                endcase
            end
        end
    end

    // Transaction payload, scan and result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg   <= command;
            owner_reg <= owner_id;
            dev_reg   <= device_kind;
            key_reg   <= key_code;
            prio_reg  <= claim_priority;
            flags_reg <= claim_flags;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end
        if (state_reg == S_SCAN)
        begin
            if (head_entry.valid)
            begin
                if (!hit_reg && head_entry.owner == owner_reg
                    && head_entry.device == dev_reg && head_entry.key == key_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cnt_reg[IDX_BITS-1:0];
                end
            end
            else if (!free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= cnt_reg[IDX_BITS-1:0];
            end
            w_found_reg <= 1'b0;
        end
        if (state_reg == S_APPLY && key_match)
        begin
            if (!w_found_reg || after.prio > w_prio_reg
                || (after.prio == w_prio_reg && after.order < w_order_reg))
            begin
                w_found_reg <= 1'b1;
                w_owner_reg <= after.owner;
                w_prio_reg  <= after.prio;
                w_order_reg <= after.order;
            end
        end
        if (state_reg == S_DONE)
        begin
            status_reg  <= ST_DONE;
            allowed_reg <= 1'b0;
            unique case (cmd_reg)
                CMD_REGISTER:
                begin
                    if (!reg_ok)
                        status_reg <= ST_INVALID;
                    else
                    begin
                        if (!hit_reg && !free_reg)
                            status_reg <= ST_FULL;
                        allowed_reg <= w_found_reg && w_owner_reg == owner_reg;
                    end
                end
                CMD_UNREG:
                    if (owner_reg == '0) status_reg <= ST_IGNORED;
                CMD_SET:
                    if (owner_reg == '0 || !enable_reg) status_reg <= ST_IGNORED;
                CMD_CLEAR:
                    if (owner_reg == '0 || active_reg != owner_reg)
                        status_reg <= ST_IGNORED;
                CMD_QUERY:
                begin
                    if (!enable_reg)
                        allowed_reg <= 1'b1;
                    else if (owner_reg == '0)
                        allowed_reg <= 1'b0;
                    else if (active_reg != '0 && active_reg != owner_reg)
                        allowed_reg <= 1'b0;
                    else if (active_reg == owner_reg)
                        allowed_reg <= 1'b1;
                    else
                        allowed_reg <= !(w_found_reg && w_owner_reg != owner_reg);
                end
                default:
                    status_reg <= ST_IGNORED;
            endcase
        end
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign allowed           = allowed_reg;
    assign active_owner_now  = active_reg;
    assign blocked_by_active = enable_reg && active_reg != '0 && active_reg != owner_reg;
    assign winner_owner      = w_found_reg ? w_owner_reg : '0;
    assign winner_priority   = w_found_reg ? w_prio_reg : '0;
endmodule
`default_nettype wire

[verif/tb_keyed_priority_reservation_arbiter_unit.sv]
// Testbench for the keyed priority reservation arbiter: predictor, driver and monitor
`default_nettype none
module tb_keyed_priority_reservation_arbiter_unit;
    import kpra_pkg::*;

    typedef struct {
        logic [2:0]         cmd;
        logic [7:0]         owner;
        logic               dev;
        logic [31:0]        key;
        logic signed [31:0] prio;
        logic [31:0]        flags;
    } claim_t;

    typedef struct {
        logic [1:0]         st;
        logic               allow;
        logic               blocked;
        logic [7:0]         act;
        logic [7:0]         win_owner;
        logic signed [31:0] win_prio;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b1;
    logic start = 1'b0;
    logic busy;
    logic [2:0] command = '0;
    logic [7:0] owner_id = '0;
    logic device_kind = 1'b0;
    logic [31:0] key_code = '0;
    logic signed [31:0] claim_priority = '0;
    logic [31:0] claim_flags = '0;
    logic done;
    logic [1:0] status;
    logic allowed;
    logic blocked_by_active;
    logic [7:0] active_owner_now;
    logic [7:0] winner_owner;
    logic signed [31:0] winner_priority;

    keyed_priority_reservation_arbiter_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .command(command), .owner_id(owner_id),
        .device_kind(device_kind), .key_code(key_code),
        .claim_priority(claim_priority), .claim_flags(claim_flags),
        .done(done), .status(status), .allowed(allowed),
        .blocked_by_active(blocked_by_active),
        .active_owner_now(active_owner_now), .winner_owner(winner_owner),
        .winner_priority(winner_priority)
    );

    // Shadow copy of the reservation table
    logic               rv_valid [TABLE_ENTRIES];
    logic [7:0]         rv_owner [TABLE_ENTRIES];
    logic               rv_dev   [TABLE_ENTRIES];
    logic [31:0]        rv_key   [TABLE_ENTRIES];
    logic signed [31:0] rv_prio  [TABLE_ENTRIES];
    logic [63:0]        rv_order [TABLE_ENTRIES];
    logic [63:0]        seq_count;
    logic [7:0]         holder;
    logic               arb_on;

    claim_t   pending_claims[$];
    verdict_t expected_verdicts[$];
    int errors = 0;
    int accepted = 0;
    int checked = 0;
    int n_full = 0;
    int n_hold = 0;
    logic drain_hold = 1'b0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int winner_slot(logic dev, logic [31:0] key);
        int best;
        best = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (rv_valid[i] && rv_dev[i] == dev && rv_key[i] == key)
            begin
                if (best < 0 || rv_prio[i] > rv_prio[best] ||
                    (rv_prio[i] == rv_prio[best] && rv_order[i] < rv_order[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    // Apply one command to the shadow state and return the expected response
    function automatic verdict_t arbitrate(claim_t c);
        verdict_t v;
        int hit;
        int free_slot;
        int w;
        v = '{ST_DONE, 1'b0, 1'b0, 8'd0, 8'd0, 32'sd0};
        case (c.cmd)
            CMD_REGISTER:
            begin
                if (c.owner == 0 || c.key == 0)
                    v.st = ST_INVALID;
                else
                begin
                    hit = -1;
                    free_slot = -1;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (rv_valid[i])
                        begin
                            if (hit < 0 && rv_owner[i] == c.owner && rv_dev[i] == c.dev &&
                                rv_key[i] == c.key)
                                hit = i;
                        end
                        else if (free_slot < 0)
                            free_slot = i;
                    end
                    if (hit >= 0)
                        rv_prio[hit] = c.prio;
                    else if (free_slot >= 0)
                    begin
                        seq_count++;
                        rv_valid[free_slot] = 1'b1;
                        rv_owner[free_slot] = c.owner;
                        rv_dev[free_slot] = c.dev;
                        rv_key[free_slot] = c.key;
                        rv_prio[free_slot] = c.prio;
                        rv_order[free_slot] = seq_count;
                    end
                    else
                    begin
                        v.st = ST_FULL;
                        n_full++;
                    end
                    w = winner_slot(c.dev, c.key);
                    v.allow = (w >= 0 && rv_owner[w] == c.owner);
                end
            end
            CMD_UNREG:
            begin
                if (c.owner == 0)
                    v.st = ST_IGNORED;
                else
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (rv_valid[i] && rv_owner[i] == c.owner)
                            rv_valid[i] = 1'b0;
                    if (holder == c.owner)
                        holder = 0;
                end
            end
            CMD_SET:
            begin
                if (c.owner == 0 || !arb_on)
                    v.st = ST_IGNORED;
                else
                    holder = c.owner;
            end
            CMD_CLEAR:
            begin
                if (c.owner == 0 || holder != c.owner)
                    v.st = ST_IGNORED;
                else
                    holder = 0;
            end
            CMD_QUERY:
            begin
                if (!arb_on)
                    v.allow = 1'b1;
                else if (c.owner == 0)
                    v.allow = 1'b0;
                else if (holder != 0 && holder != c.owner)
                    v.allow = 1'b0;
                else if (holder == c.owner)
                    v.allow = 1'b1;
                else
                begin
                    w = winner_slot(c.dev, c.key);
                    v.allow = !(w >= 0 && rv_owner[w] != c.owner);
                end
            end
            default:
                v.st = ST_IGNORED;
        endcase
        w = winner_slot(c.dev, c.key);
        v.blocked = arb_on && holder != 0 && holder != c.owner;
        v.act = holder;
        if (w >= 0)
        begin
            v.win_owner = rv_owner[w];
            v.win_prio = rv_prio[w];
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %0s at transaction %0d: got %0h want %0h", what, checked, got, want);
        errors++;
    endtask

    // Driver: bursts with random gaps, hold-off while a drain is requested
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge clk)
    begin
        claim_t c;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                accepted++;
            end
            if (start && busy)
            begin
                // hold the current transaction
            end
            else if (drain_hold || pending_claims.size() == 0)
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else
            begin
                c = pending_claims.pop_front();
                expected_verdicts.push_back(arbitrate(c));
                command <= c.cmd;
                owner_id <= c.owner;
                device_kind <= c.dev;
                key_code <= c.key;
                claim_priority <= c.prio;
                claim_flags <= c.flags;
                start <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("unexpected result at transaction %0d", checked);
                errors++;
            end
            else
            begin
                v = expected_verdicts.pop_front();
                if (status !== v.st)
                    report_mismatch("status", status, v.st);
                if (allowed !== v.allow)
                    report_mismatch("allowed", allowed, v.allow);
                if (blocked_by_active !== v.blocked)
                    report_mismatch("blocked_by_active", blocked_by_active, v.blocked);
                if (active_owner_now !== v.act)
                    report_mismatch("active_owner_now", active_owner_now, v.act);
                if (winner_owner !== v.win_owner)
                    report_mismatch("winner_owner", winner_owner, v.win_owner);
                if (winner_priority !== v.win_prio)
                    report_mismatch("winner_priority", winner_priority, v.win_prio);
            end
            checked++;
        end
    end

    function automatic claim_t mk(logic [2:0] cmd, logic [7:0] owner, logic dev,
                                  logic [31:0] key, logic [31:0] prio, logic [31:0] flags);
        claim_t c;
        c.cmd = cmd;
        c.owner = owner;
        c.dev = dev;
        c.key = key;
        c.prio = prio;
        c.flags = flags;
        return c;
    endfunction

    // Random command drawn from a small pool of owners and keys to force collisions
    function automatic claim_t random_claim();
        claim_t c;
        int r;
        r = $urandom_range(0, 99);
        c.cmd = (r < 45) ? CMD_REGISTER : (r < 53) ? CMD_UNREG : (r < 60) ? CMD_SET :
                (r < 66) ? CMD_CLEAR : (r < 97) ? CMD_QUERY : 3'($urandom_range(5, 7));
        c.owner = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        c.dev = 1'($urandom);
        c.key = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 5));
        c.prio = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 4) - 2);
        c.flags = $urandom;
        return c;
    endfunction

    // Let queued commands go out, then hold the sender until every result is back
    task automatic wait_idle();
        while (pending_claims.size() != 0)
            @(posedge clk);
        drain_hold = 1'b1;
        while (expected_verdicts.size() != 0 || start)
            @(posedge clk);
        repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);
        n_hold++;
    endtask

    task automatic write_enable(logic val);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        arb_on = val;
        if (!val)
            holder = 0;
        drain_hold = 1'b0;
    endtask

    // Stimulus and end of run
    initial
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            rv_valid[i] = 1'b0;
            rv_owner[i] = '0;
            rv_dev[i] = 1'b0;
            rv_key[i] = '0;
            rv_prio[i] = '0;
            rv_order[i] = '0;
        end
        seq_count = '0;
        holder = '0;
        arb_on = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        write_enable(1'b1);

        // Directed: rejects, update in place, ties, active ownership, extremes
        pending_claims.push_back(mk(CMD_REGISTER, 8'd0, 1'b0, 32'd5, 32'd1, '1));
        pending_claims.push_back(mk(CMD_REGISTER, 8'd3, 1'b0, 32'd0, 32'd1, '1));
        pending_claims.push_back(mk(CMD_REGISTER, 8'd3, 1'b1, '1, 32'h7fffffff, '1));
        pending_claims.push_back(mk(CMD_REGISTER, 8'hff, 1'b1, '1, 32'h7fffffff, '0));
        pending_claims.push_back(mk(CMD_QUERY, 8'hff, 1'b1, '1, '0, '0));
        pending_claims.push_back(mk(CMD_REGISTER, 8'd3, 1'b1, '1, 32'h80000000, '0));
        pending_claims.push_back(mk(CMD_QUERY, 8'd3, 1'b1, '1, '0, '0));
        pending_claims.push_back(mk(CMD_QUERY, 8'd0, 1'b1, '1, '0, '0));
        pending_claims.push_back(mk(CMD_SET, 8'd0, 1'b0, 32'd1, '0, '0));
        pending_claims.push_back(mk(CMD_SET, 8'd3, 1'b0, 32'd1, '0, '0));
        pending_claims.push_back(mk(CMD_SET, 8'd3, 1'b0, 32'd1, '0, '0));
        pending_claims.push_back(mk(CMD_QUERY, 8'hff, 1'b1, '1, '0, '0));
        pending_claims.push_back(mk(CMD_CLEAR, 8'hff, 1'b0, 32'd1, '0, '0));
        pending_claims.push_back(mk(CMD_CLEAR, 8'd0, 1'b0, 32'd1, '0, '0));
        pending_claims.push_back(mk(CMD_CLEAR, 8'd3, 1'b0, 32'd1, '0, '0));
        pending_claims.push_back(mk(CMD_SET, 8'hff, 1'b0, 32'd1, '0, '0));
        pending_claims.push_back(mk(CMD_UNREG, 8'd0, 1'b0, 32'd1, '0, '0));
        pending_claims.push_back(mk(CMD_UNREG, 8'hff, 1'b1, '1, '0, '0));
        pending_claims.push_back(mk(3'd5, 8'd1, 1'b0, 32'd1, '0, '0));
        pending_claims.push_back(mk(3'd7, 8'hff, 1'b1, '1, '1, '1));
        write_enable(1'b0);
        pending_claims.push_back(mk(CMD_SET, 8'd4, 1'b0, '1, '0, '0));
        pending_claims.push_back(mk(CMD_QUERY, 8'd0, 1'b1, '1, '0, '0));
        pending_claims.push_back(mk(CMD_REGISTER, 8'd9, 1'b1, '1, 32'd5, '1));
        write_enable(1'b1);

        // Fill the table to exercise the full case, then drain it
        for (int i = 0; i < TABLE_ENTRIES + 3; i++)
            pending_claims.push_back(mk(CMD_REGISTER, 8'($urandom_range(1, 4)), 1'($urandom),
                                        32'(i + 1), $urandom, $urandom));
        pending_claims.push_back(mk(CMD_REGISTER, 8'd2, 1'b0, 32'd1, 32'd1, '0));
        for (int o = 1; o <= 4; o++)
            pending_claims.push_back(mk(CMD_UNREG, 8'(o), 1'b0, 32'd1, '0, '0));

        // Random phases with enable toggles between them
        for (int ph = 0; ph < 6; ph++)
        begin
            repeat (230) pending_claims.push_back(random_claim());
            write_enable(ph % 3 != 1);
            pending_claims.push_back(mk(CMD_SET, 8'($urandom_range(1, 6)), 1'b0, 32'd1, '0, '0));
        end
        repeat (40) pending_claims.push_back(random_claim());

        while (pending_claims.size() != 0 || start)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);
        $display("covered %0d commands, %0d table-full rejects, %0d idle points",
                 checked, n_full, n_hold);
        if (errors == 0 && expected_verdicts.size() == 0)
            $display("PASS keyed_priority_reservation_arbiter_unit");
        else
            $display("FAIL keyed_priority_reservation_arbiter_unit");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAIL keyed_priority_reservation_arbiter_unit");
        $finish;
    end
endmodule
`default_nettype wire
